FILE: rtl/sacm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacm_pkg: shared types and constants of the cache hit/miss core
// field widths, register codes, reset values and the replacement lfsr
// ----------------------------------------------------------------------------
package sacm_pkg;

  // fixed field widths
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int CNT_W      = 32;
  localparam int WAY_OUT_W  = 3;
  localparam int SF_W       = 15;  // widest set field (set_bits at most 15)
  localparam int SHIFT_W    = 6;   // offset_bits + set_bits, at most 46

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd3;

  localparam logic [4:0]  OFFSET_BITS_RST = 5'd5;
  localparam logic [3:0]  SET_BITS_RST    = 4'd6;
  localparam logic [3:0]  WAYS_RST        = 4'd4;

  // replacement lfsr
  localparam int          LFSR_W    = 16;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] SEED_RST  = 16'd44257;

  // remainder unit: bits retired per cycle and step counter
  localparam int MOD_BITS_PER_CYCLE = 4;
  localparam int MOD_STEPS          = LFSR_W / MOD_BITS_PER_CYCLE;
  localparam int MOD_CNT_W          = 2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SPLIT,
    S_INDEX,
    S_CMP,
    S_MOD
  } sacm_state_e;

  typedef struct packed {
    logic              start;
    logic [LFSR_W-1:0] dividend;
  } sacm_mod_req_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

FILE: rtl/sacm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacm_req_if: lookup request channel
// one address word per valid/ready handshake
// ----------------------------------------------------------------------------
interface sacm_req_if;
  import sacm_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);

endinterface

FILE: rtl/sacm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacm_rsp_if: lookup result channel
// hit flag, way and running counters per valid/ready handshake
// ----------------------------------------------------------------------------
interface sacm_rsp_if;
  import sacm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     miss_count;

  modport source (output valid, output hit, output way, output hit_count,
                  output miss_count, input ready);
  modport sink   (input valid, input hit, input way, input hit_count,
                  input miss_count, output ready);

endinterface

FILE: rtl/sacm_way_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacm_way_mod: victim way remainder unit
// restoring remainder of the lfsr word by the ways in use, 4 bits a cycle
// ----------------------------------------------------------------------------
module sacm_way_mod #(
  parameter int DIV_W = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sacm_pkg::sacm_mod_req_t req_i,
  input  logic [DIV_W-1:0]       divisor_i,
  output logic                   done_o,
  output logic [DIV_W-1:0]       rem_o
);
  import sacm_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [LFSR_W-1:0]    dvd_q, dvd_n;
  logic [DIV_W-1:0]     rem_q, rem_n;
  logic [DIV_W:0]       trial;

  // four dependent shift/compare/subtract steps
  always_comb begin
    rem_n = rem_q;
    dvd_n = dvd_q;
    trial = '0;
    for (int k = 0; k < MOD_BITS_PER_CYCLE; k++) begin
      trial = {rem_n, dvd_n[LFSR_W-1]};
      if (trial >= {1'b0, divisor_i}) begin
        trial = trial - {1'b0, divisor_i};
      end
      rem_n = trial[DIV_W-1:0];
      dvd_n = {dvd_n[LFSR_W-2:0], 1'b0};
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_n;
      rem_q <= rem_n;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/set_assoc_cache_hit_miss_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_miss_core: set-associative tag lookup, random victim
// tag store in one synchronous memory, one row of ways per set
// ----------------------------------------------------------------------------
// usage
//   req_i carries one address word per handshake; rsp_o returns one result
//   word per request: hit flag, way (hit way or victim way), and the saturating
//   hit and miss counters including that request.
//   cfg_we_i/cfg_idx_i/cfg_data_i write offset_bits, set_bits, ways_in_use and
//   the lfsr seed (writing the seed reloads the lfsr); write only when idle.
// flow
//   one request in flight. a hit passes the split, index (tag memory read) and
//   compare states and, once the output slot is free, loads the output register;
//   the next request is taken back in idle. a miss adds the victim remainder unit
//   (4 bits a cycle) and writes the new tag back as its result is loaded.
// reset
//   after reset a clearing pass writes zero to every row, during which req_i
//   is not ready; config writes are accepted meanwhile.
// stalls
//   the result sits in an output register; a new request is accepted while it
//   waits, and the following result holds in place until rsp_o is taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_miss_core #(
  parameter int MAX_SETS     = 256,
  parameter int MAX_WAYS     = 8,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sacm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sacm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sacm_req_if.sink                        req_i,
  sacm_rsp_if.source                      rsp_o
);
  import sacm_pkg::*;

  localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYCNT_W  = $clog2(MAX_WAYS + 1);

  // address mask for narrower address spaces
  localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ? '1 :
                                            ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

  // set field modulo MAX_SETS: reciprocal estimate, one correction step
  localparam logic [16:0]      RECIP    = 17'((1 << 16) / MAX_SETS);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

  typedef logic [MAX_WAYS-1:0][TAG_W-1:0] row_t;

  // tag memory
  row_t mem [MAX_SETS];
  row_t rdata_q;

  sacm_state_e state_q, state_d;

  // configuration registers
  logic [4:0]        offset_bits_q;
  logic [3:0]        set_bits_q;
  logic [3:0]        ways_q;
  logic [LFSR_W-1:0] lfsr_q;
  logic [LFSR_W-1:0] lfsr_nxt;

  logic [WAYCNT_W-1:0] eff_ways;

  // request payload through the lookup
  logic [ADDR_W-1:0] addr_q;
  logic [SF_W-1:0]   sf_q, sf_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [31:0]       prod_q, prod_d;
  logic [SET_W-1:0]  set_q, rd_set;
  logic [SHIFT_W-1:0] tshift;
  logic [ADDR_W-1:0] off_shifted;
  logic [31:0]       qm;
  logic [31:0]       r_wide;
  logic [SET_W:0]    r_est;
  logic [SET_W:0]    r_fix;

  // clearing pass
  logic [SET_W-1:0] clr_cnt_q;

  // compare and replace
  logic                 hit_found;
  logic [WAY_IDX_W-1:0] hit_way;
  logic [WAY_IDX_W-1:0] victim_way;
  logic [WAY_IDX_W-1:0] res_way;
  logic [WAY_IDX_W+2:0] res_way_ext;
  row_t                 wr_row;
  logic [SET_W-1:0]     wr_set;
  logic                 rd_en, wr_en;

  // remainder unit
  sacm_mod_req_t       mod_req;
  logic                mod_done;
  logic [WAYCNT_W-1:0] mod_rem;

  // counters and output register
  logic [CNT_W-1:0]     hits_q, misses_q;
  logic                 out_valid_q;
  logic                 out_hit_q;
  logic [WAY_OUT_W-1:0] out_way_q;
  logic                 slot_free;
  logic                 finish;
  logic                 lfsr_step;
  logic                 accept;

  // ways_in_use of 0 acts as 1, above MAX_WAYS clamps
  always_comb begin
    if (ways_q == 4'd0) begin
      eff_ways = WAYCNT_W'(1);
    end else if ({1'b0, ways_q} > 5'(MAX_WAYS)) begin
      eff_ways = WAYCNT_W'(MAX_WAYS);
    end else begin
      eff_ways = WAYCNT_W'(ways_q);
    end
  end

  // address split: set field and tag, plus reciprocal product
  always_comb begin
    off_shifted = addr_q >> offset_bits_q;
    sf_d        = off_shifted[SF_W-1:0] & ~({SF_W{1'b1}} << set_bits_q);
    tshift      = SHIFT_W'(offset_bits_q) + SHIFT_W'(set_bits_q);
    tag_d       = addr_q >> tshift;  // shifts past the word give tag 0
    prod_d      = 32'(sf_d) * 32'(RECIP);
  end

  // set index = sf mod MAX_SETS; estimate is low by at most one
  always_comb begin
    qm     = 32'(prod_q[31:16]) * 32'(MAX_SETS);
    r_wide = 32'(sf_q) - qm;
    r_est  = r_wide[SET_W:0];
    if (r_est >= (SET_W+1)'(MAX_SETS)) begin
      r_fix = r_est - (SET_W+1)'(MAX_SETS);
    end else begin
      r_fix = r_est;
    end
    rd_set = r_fix[SET_W-1:0];
  end

  // tag compare, lowest way wins
  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if ((WAYCNT_W'(i) < eff_ways) && (rdata_q[i] == tag_q)) begin
        hit_found = 1'b1;
        hit_way   = WAY_IDX_W'(i);
      end
    end
  end

  assign lfsr_nxt   = lfsr_next(lfsr_q);
  assign victim_way = WAY_IDX_W'(mod_rem);
  assign slot_free  = !out_valid_q || rsp_o.ready;
  assign accept     = req_i.valid && req_i.ready;

  always_comb begin
    wr_row             = rdata_q;
    wr_row[victim_way] = tag_q;
    if (state_q == S_CLEAR) begin
      wr_row = '0;
    end
  end

  assign wr_set = (state_q == S_CLEAR) ? clr_cnt_q : set_q;

  // control
  always_comb begin
    state_d          = state_q;
    req_i.ready      = 1'b0;
    rd_en            = 1'b0;
    wr_en            = 1'b0;
    finish           = 1'b0;
    lfsr_step        = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = lfsr_nxt;
    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (clr_cnt_q == LAST_SET) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        state_d = S_INDEX;
      end
      S_INDEX: begin
        rd_en   = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (hit_found) begin
          if (slot_free) begin
            finish  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          // miss: step the lfsr and reduce its new value by the ways in use
          lfsr_step     = 1'b1;
          mod_req.start = 1'b1;
          state_d       = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done && slot_free) begin
          finish  = 1'b1;
          wr_en   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  sacm_way_mod #(
    .DIV_W (WAYCNT_W)
  ) u_way_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mod_req),
    .divisor_i (eff_ways),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  // tag memory, one read or one write a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_set];
    end
  end

  // control state, configuration, lfsr and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_cnt_q     <= '0;
      offset_bits_q <= OFFSET_BITS_RST;
      set_bits_q    <= SET_BITS_RST;
      ways_q        <= WAYS_RST;
      lfsr_q        <= SEED_RST;
      hits_q        <= '0;
      misses_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i[4:0];
          CFG_SET_BITS:    set_bits_q    <= cfg_data_i[3:0];
          CFG_WAYS_IN_USE: ways_q        <= cfg_data_i[3:0];
          CFG_RANDOM_SEED: lfsr_q        <= cfg_data_i;
          default: ;
        endcase
      end else if (lfsr_step) begin
        lfsr_q <= lfsr_nxt;
      end
      if (finish) begin
        if (state_q == S_CMP) begin
          if (hits_q != '1) begin
            hits_q <= hits_q + 1'b1;
          end
        end else if (misses_q != '1) begin
          misses_q <= misses_q + 1'b1;
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  assign res_way     = (state_q == S_CMP) ? hit_way : victim_way;
  assign res_way_ext = (WAY_IDX_W+3)'(res_way);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= req_i.address & ADDR_MASK;
    end
    if (state_q == S_SPLIT) begin
      sf_q   <= sf_d;
      tag_q  <= tag_d;
      prod_q <= prod_d;
    end
    if (rd_en) begin
      set_q <= rd_set;
    end
    if (finish) begin
      out_hit_q <= (state_q == S_CMP);
      out_way_q <= res_way_ext[WAY_OUT_W-1:0];
    end
  end

  // counters change only when the next result is loaded, so they stay in
  // step with the word in the output register
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.way        = out_way_q;
  assign rsp_o.hit_count  = hits_q;
  assign rsp_o.miss_count = misses_q;

endmodule
